[sv/gtp_pkg.sv]
// Package for the GUID text parser: style codes, FSM states, string templates
// and the hex digit decoder. No dependencies.
package gtp_pkg;

  localparam int POS_W = 7;
  localparam int TPL_MAX = 68;
  localparam logic [7:0] TPL_DIGIT = 8'h48;  // 'H' marks a hex digit position

  typedef enum logic [2:0] {
    STY_AUTO = 3'd0,
    STY_HEX  = 3'd1,
    STY_HYP  = 3'd2,
    STY_BRC  = 3'd3,
    STY_PAR  = 3'd4,
    STY_VAL  = 3'd5,
    STY_W64  = 3'd6,
    STY_BAD  = 3'd7
  } style_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DONE
  } state_t;

  localparam logic [7:0] CH_LBRACE = 8'h7B;

  localparam logic [8*TPL_MAX-1:0] TPL_HEX = "HHHHHHHHHHHHHHHHHHHHHHHHHHHHHHHH";
  localparam logic [8*TPL_MAX-1:0] TPL_HYP = "HHHHHHHH-HHHH-HHHH-HHHH-HHHHHHHHHHHH";
  localparam logic [8*TPL_MAX-1:0] TPL_BRC = "{HHHHHHHH-HHHH-HHHH-HHHH-HHHHHHHHHHHH}";
  localparam logic [8*TPL_MAX-1:0] TPL_PAR = "(HHHHHHHH-HHHH-HHHH-HHHH-HHHHHHHHHHHH)";
  localparam logic [8*TPL_MAX-1:0] TPL_VAL =
    "{0xHHHHHHHH,0xHHHH,0xHHHH,{0xHH,0xHH,0xHH,0xHH,0xHH,0xHH,0xHH,0xHH}}";
  localparam logic [8*TPL_MAX-1:0] TPL_W64 = "HHHHHHHHHHHHHHHH-HHHHHHHHHHHHHHHH";

  function automatic logic [POS_W-1:0] style_len(style_t s);
    unique case (s)
      STY_HEX: return 7'd32;
      STY_HYP: return 7'd36;
      STY_BRC: return 7'd38;
      STY_PAR: return 7'd38;
      STY_VAL: return 7'd68;
      STY_W64: return 7'd33;
      default: return 7'd0;
    endcase
  endfunction

  // Template character at a position, first character is position 0.
  function automatic logic [7:0] tpl_char(style_t s, logic [POS_W-1:0] pos);
    logic [8*TPL_MAX-1:0] t;
    int sh;
    unique case (s)
      STY_HEX: t = TPL_HEX;
      STY_HYP: t = TPL_HYP;
      STY_BRC: t = TPL_BRC;
      STY_PAR: t = TPL_PAR;
      STY_VAL: t = TPL_VAL;
      STY_W64: t = TPL_W64;
      default: t = '0;
    endcase
    sh = 8 * (int'(style_len(s)) - 1 - int'(pos));
    if (sh < 0) begin
      return 8'h00;
    end
    return t[sh +: 8];
  endfunction

  // 0..15 for a hex digit, bit 4 set otherwise.
  function automatic logic [4:0] hex_value(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return {1'b0, 4'(c - 8'h30)};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      return {1'b0, 4'(c - 8'h57)};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      return {1'b0, 4'(c - 8'h37)};
    end
    return 5'h10;
  endfunction

endpackage

[sv/guid_text_parser.sv]
// GUID text parser top level: character store, style check and digit walk.
// Depends on gtp_pkg.
//
// Usage:
//  - Input: drive in_char_code/in_last_char with in_start high; a character
//    is taken on a clock edge where in_start is high and busy is low.
//  - Ordinary characters load one per cycle and busy stays low.
//  - On the character marked in_last_char the block goes busy. If length and
//    style agree it walks the stored string one character per cycle through
//    a single decode/compare/shift unit, reading through the one read port of
//    the character memory. A string rejected by length or style goes straight
//    to the result.
//  - Result: out_strobe is high for one cycle with out_guid_valid,
//    out_guid_high and out_guid_low (halves are zero when invalid). The
//    receiver cannot stall; the result must be taken in that cycle.
//  - Config: cfg_wr_en writes cfg_parse_style (0 auto, 1..6 fixed styles).
//    Write only while idle.
//  - Reset: character count and style clear, no result pending. The store
//    itself is not cleared; only written entries are ever read.
module guid_text_parser #(
  parameter int MAX_CHARS = 68
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_start,
  output logic        busy,
  input  logic [7:0]  in_char_code,
  input  logic        in_last_char,
  output logic        out_strobe,
  output logic        out_guid_valid,
  output logic [63:0] out_guid_high,
  output logic [63:0] out_guid_low,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_parse_style
);

  localparam int CNT_W = $clog2(MAX_CHARS + 2);
  localparam int IDX_W = $clog2(MAX_CHARS);
  localparam int POS_W = gtp_pkg::POS_W;

  gtp_pkg::state_t state_r, state_nxt;
  gtp_pkg::style_t cfg_style_r;
  gtp_pkg::style_t style_r, style_nxt;

  logic [7:0]       mem [MAX_CHARS];
  logic [7:0]       rd_data_r;
  logic [IDX_W-1:0] rd_addr;

  logic [CNT_W-1:0] cnt_r, cnt_nxt, len;
  logic [7:0]       first_r, first_nxt;
  logic [POS_W-1:0] len_r, len_nxt;
  logic [POS_W-1:0] ptr_r, ptr_nxt;
  logic [POS_W-1:0] chk_r, chk_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             ok_r, ok_nxt;
  logic [127:0]     acc_r, acc_nxt;

  logic             accept, scan_en, issue, pre_ok, last_chk;
  logic [7:0]       tpl;
  logic [4:0]       hv;

  // Outputs of the sequencer
  always_comb begin
    busy       = 1'b1;
    out_strobe = 1'b0;
    scan_en    = 1'b0;
    unique case (state_r)
      gtp_pkg::ST_LOAD: busy = 1'b0;
      gtp_pkg::ST_SCAN: scan_en = 1'b1;
      gtp_pkg::ST_DONE: out_strobe = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  assign accept = in_start && !busy;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gtp_pkg::ST_LOAD: begin
        if (accept && in_last_char) begin
          state_nxt = pre_ok ? gtp_pkg::ST_SCAN : gtp_pkg::ST_DONE;
        end
      end
      gtp_pkg::ST_SCAN: begin
        if (last_chk) begin
          state_nxt = gtp_pkg::ST_DONE;
        end
      end
      gtp_pkg::ST_DONE: state_nxt = gtp_pkg::ST_LOAD;
      default: state_nxt = gtp_pkg::ST_LOAD;
    endcase
  end

  // Length and style resolution at the last character
  always_comb begin
    len = (cnt_r <= CNT_W'(MAX_CHARS)) ? cnt_r + CNT_W'(1) : cnt_r;
    style_nxt = cfg_style_r;
    if (cfg_style_r == gtp_pkg::STY_AUTO) begin
      case (len)
        CNT_W'(32): style_nxt = gtp_pkg::STY_HEX;
        CNT_W'(36): style_nxt = gtp_pkg::STY_HYP;
        CNT_W'(38): style_nxt = (first_r == gtp_pkg::CH_LBRACE) ?
                                gtp_pkg::STY_BRC : gtp_pkg::STY_PAR;
        CNT_W'(68): style_nxt = gtp_pkg::STY_VAL;
        CNT_W'(33): style_nxt = gtp_pkg::STY_W64;
        default:    style_nxt = gtp_pkg::STY_BAD;
      endcase
    end
    pre_ok = (style_nxt != gtp_pkg::STY_AUTO) && (style_nxt != gtp_pkg::STY_BAD) &&
             (len <= CNT_W'(MAX_CHARS)) &&
             (len == CNT_W'(gtp_pkg::style_len(style_nxt)));
  end

  // Load counters and scan datapath
  always_comb begin
    cnt_nxt    = cnt_r;
    first_nxt  = first_r;
    len_nxt    = len_r;
    ptr_nxt    = ptr_r;
    chk_nxt    = chk_r;
    rd_vld_nxt = 1'b0;
    ok_nxt     = ok_r;
    acc_nxt    = acc_r;

    tpl      = gtp_pkg::tpl_char(style_r, chk_r);
    hv       = gtp_pkg::hex_value(rd_data_r);
    issue    = scan_en && (ptr_r < len_r);
    last_chk = rd_vld_r && (chk_r == len_r - POS_W'(1));
    rd_addr  = IDX_W'(ptr_r);

    if (accept) begin
      if (cnt_r == '0) begin
        first_nxt = in_char_code;
      end
      if (in_last_char) begin
        cnt_nxt = '0;
        len_nxt = POS_W'(len);
        ptr_nxt = '0;
        ok_nxt  = pre_ok;
        acc_nxt = '0;
      end else begin
        cnt_nxt = len;
      end
    end

    if (issue) begin
      rd_vld_nxt = 1'b1;
      chk_nxt    = ptr_r;
      ptr_nxt    = ptr_r + POS_W'(1);
    end

    if (rd_vld_r) begin
      if (tpl == gtp_pkg::TPL_DIGIT) begin
        if (hv[4]) begin
          ok_nxt = 1'b0;
        end else begin
          acc_nxt = {acc_r[123:0], hv[3:0]};
        end
      end else if (rd_data_r != tpl) begin
        ok_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (cnt_r < CNT_W'(MAX_CHARS))) begin
      mem[IDX_W'(cnt_r)] <= in_char_code;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gtp_pkg::ST_LOAD;
      cfg_style_r <= gtp_pkg::STY_AUTO;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      ok_r        <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= rd_vld_nxt;
      ok_r     <= ok_nxt;
      if (cfg_wr_en) begin
        cfg_style_r <= gtp_pkg::style_t'(cfg_parse_style);
      end
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    len_r   <= len_nxt;
    ptr_r   <= ptr_nxt;
    chk_r   <= chk_nxt;
    acc_r   <= acc_nxt;
    if (accept && in_last_char) begin
      style_r <= style_nxt;
    end
  end

  assign out_guid_valid = ok_r;
  assign out_guid_high  = ok_r ? acc_r[127:64] : 64'd0;
  assign out_guid_low   = ok_r ? acc_r[63:0] : 64'd0;

endmodule

[bench/guid_text_parser_tb.sv]
// Testbench for guid_text_parser: directed GUID strings, then random strings,
// checked against a predictor of the parser. Depends on gtp_pkg and the RTL.
module guid_text_parser_tb;

  localparam int MAX_LEN = 68;
  localparam int N_DIR = 24;
  localparam byte DIGIT_MARK = "H";

  typedef struct packed {
    logic        vld;
    logic [63:0] hi;
    logic [63:0] lo;
  } guid_res_t;

  typedef struct packed {
    logic      chk;
    guid_res_t res;
  } typed_res_t;

  typedef struct {
    gtp_pkg::style_t sty;
    string           txt;
    int              rep;
    int              pos;
    logic [7:0]      sub;
    logic            chk;
    logic            vld;
    logic [63:0]     hi;
    logic [63:0]     lo;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_start = 1'b0;
  logic [7:0]  in_char_code = '0;
  logic        in_last_char = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_parse_style = '0;
  logic        busy;
  logic        out_strobe;
  logic        out_guid_valid;
  logic [63:0] out_guid_high;
  logic [63:0] out_guid_low;

  // predictor state
  logic [7:0]      txt_buf [MAX_LEN];
  int unsigned     txt_cnt = 0;
  gtp_pkg::style_t cur_style = gtp_pkg::STY_AUTO;
  guid_res_t       guid_exp_q [$];
  typed_res_t      row_exp_q [$];

  logic [7:0]  txt_q [$];
  dir_row_t    dir_tab [N_DIR];
  int          idle_pct = 14;
  int          n_sent = 0;
  int          n_err = 0;

  string HEX_SET = "0123456789abcdefABCDEF";
  string NEAR_SET = "/:@G`g";
  string LIT_SET = "-{}(),xX0";
  string MIX_SET = "0123456789abcdefABCDEF-{}(),x";

  guid_text_parser dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_start        (in_start),
    .busy            (busy),
    .in_char_code    (in_char_code),
    .in_last_char    (in_last_char),
    .out_strobe      (out_strobe),
    .out_guid_valid  (out_guid_valid),
    .out_guid_high   (out_guid_high),
    .out_guid_low    (out_guid_low),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_parse_style (cfg_parse_style)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic string style_template(gtp_pkg::style_t s);
    case (s)
      gtp_pkg::STY_HEX: return "HHHHHHHHHHHHHHHHHHHHHHHHHHHHHHHH";
      gtp_pkg::STY_HYP: return "HHHHHHHH-HHHH-HHHH-HHHH-HHHHHHHHHHHH";
      gtp_pkg::STY_BRC: return "{HHHHHHHH-HHHH-HHHH-HHHH-HHHHHHHHHHHH}";
      gtp_pkg::STY_PAR: return "(HHHHHHHH-HHHH-HHHH-HHHH-HHHHHHHHHHHH)";
      gtp_pkg::STY_VAL:
        return "{0xHHHHHHHH,0xHHHH,0xHHHH,{0xHH,0xHH,0xHH,0xHH,0xHH,0xHH,0xHH,0xHH}}";
      gtp_pkg::STY_W64: return "HHHHHHHHHHHHHHHH-HHHHHHHHHHHHHHHH";
      default: return "";
    endcase
  endfunction

  function automatic int nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  // Stores one character; on the last one works out the parse result, or takes the directed row's result if checked.
  function automatic void take_char(logic [7:0] c, logic last);
    guid_res_t       r;
    typed_res_t      tr;
    gtp_pkg::style_t s;
    string           t;
    logic [127:0]    acc;
    int              v;
    int              i;
    if (txt_cnt < MAX_LEN) txt_buf[txt_cnt] = c;
    if (txt_cnt <= MAX_LEN) txt_cnt++;
    if (!last) return;
    s = cur_style;
    if (s == gtp_pkg::STY_AUTO) begin
      case (txt_cnt)
        32: s = gtp_pkg::STY_HEX;
        36: s = gtp_pkg::STY_HYP;
        38: s = (txt_buf[0] == "{") ? gtp_pkg::STY_BRC : gtp_pkg::STY_PAR;
        68: s = gtp_pkg::STY_VAL;
        33: s = gtp_pkg::STY_W64;
        default: s = gtp_pkg::STY_BAD;
      endcase
    end
    t = style_template(s);
    r = '0;
    acc = '0;
    r.vld = (t.len() != 0) && (txt_cnt == t.len());
    for (i = 0; r.vld && i < int'(txt_cnt); i++) begin
      if (t[i] == DIGIT_MARK) begin
        v = nibble_of(txt_buf[i]);
        if (v < 0) r.vld = 1'b0;
        else acc = {acc[123:0], 4'(v)};
      end else if (txt_buf[i] != t[i]) begin
        r.vld = 1'b0;
      end
    end
    if (r.vld) begin
      r.hi = acc[127:64];
      r.lo = acc[63:0];
    end
    if (row_exp_q.size() != 0) begin
      tr = row_exp_q.pop_front();
      if (tr.chk) r = tr.res;
    end
    guid_exp_q.push_back(r);
    txt_cnt = 0;
  endfunction

  always @(posedge clk) begin : mon
    guid_res_t e;
    if (rst_n) begin
      if (out_strobe) begin
        if (guid_exp_q.size() == 0) begin
          $error("result with nothing expected");
          n_err++;
        end else begin
          e = guid_exp_q.pop_front();
          if (out_guid_valid !== e.vld) begin
            $error("guid_valid: expected %0b, got %0b", e.vld, out_guid_valid);
            n_err++;
          end
          if (out_guid_high !== e.hi) begin
            $error("guid_high: expected %h, got %h", e.hi, out_guid_high);
            n_err++;
          end
          if (out_guid_low !== e.lo) begin
            $error("guid_low: expected %h, got %h", e.lo, out_guid_low);
            n_err++;
          end
        end
      end
      if (in_start && !busy) take_char(in_char_code, in_last_char);
    end
  end

  task automatic send_char(logic [7:0] c, logic last);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_start <= 1'b1;
    in_char_code <= c;
    in_last_char <= last;
    do @(posedge clk); while (busy);
    n_sent++;
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < txt_q.size(); i++) send_char(txt_q[i], i == txt_q.size() - 1);
  endtask

  task automatic set_style(gtp_pkg::style_t s);
    in_start <= 1'b0;
    @(posedge clk);
    while (guid_exp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_parse_style <= s;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_style = s;
  endtask

  // Mostly well-formed strings with random digits, some damaged, some noise.
  task automatic build_text();
    int              k;
    int              m;
    int              p;
    int              n;
    int              i;
    gtp_pkg::style_t s;
    string           t;
    txt_q.delete();
    k = $urandom_range(0, 99);
    if (k < 15) begin
      n = $urandom_range(1, 80);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 1)) txt_q.push_back(8'($urandom_range(0, 255)));
        else txt_q.push_back(MIX_SET[$urandom_range(0, MIX_SET.len() - 1)]);
      end
      return;
    end
    if (cur_style != gtp_pkg::STY_AUTO && cur_style != gtp_pkg::STY_BAD &&
        $urandom_range(0, 9) < 7)
      s = cur_style;
    else
      s = gtp_pkg::style_t'($urandom_range(1, 6));
    t = style_template(s);
    for (i = 0; i < t.len(); i++) begin
      if (t[i] == DIGIT_MARK) txt_q.push_back(HEX_SET[$urandom_range(0, HEX_SET.len() - 1)]);
      else txt_q.push_back(t[i]);
    end
    if (k >= 75) begin
      m = $urandom_range(0, 3);
      p = $urandom_range(0, txt_q.size() - 1);
      case (m)
        0: txt_q[p] = 8'($urandom_range(0, 255));
        1: begin
          if (t[p] == DIGIT_MARK) txt_q[p] = NEAR_SET[$urandom_range(0, NEAR_SET.len() - 1)];
          else txt_q[p] = LIT_SET[$urandom_range(0, LIT_SET.len() - 1)];
        end
        2: txt_q.delete(p);
        default: txt_q.insert(p, HEX_SET[$urandom_range(0, HEX_SET.len() - 1)]);
      endcase
    end
  endtask

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin : main
    int         r;
    int         i;
    int         ph;
    int         goal;
    int         n_str;
    int         next_cfg;
    typed_res_t tr;
    dir_tab = '{
      '{gtp_pkg::STY_AUTO, "0123456789abcdefFEDCBA9876543210", 1, -1, 8'h00,
        1'b1, 1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210},
      '{gtp_pkg::STY_AUTO, "01234567-89ab-cdef-0123-456789abcdef", 1, -1, 8'h00,
        1'b1, 1'b1, 64'h0123456789abcdef, 64'h0123456789abcdef},
      '{gtp_pkg::STY_AUTO, "{01234567-89ab-cdef-0123-456789abcdef}", 1, -1, 8'h00,
        1'b1, 1'b1, 64'h0123456789abcdef, 64'h0123456789abcdef},
      '{gtp_pkg::STY_AUTO, "(01234567-89ab-cdef-0123-456789abcdef)", 1, -1, 8'h00,
        1'b1, 1'b1, 64'h0123456789abcdef, 64'h0123456789abcdef},
      '{gtp_pkg::STY_AUTO,
        "{0x01234567,0x89ab,0xcdef,{0x01,0x23,0x45,0x67,0x89,0xab,0xcd,0xef}}",
        1, -1, 8'h00, 1'b1, 1'b1, 64'h0123456789abcdef, 64'h0123456789abcdef},
      '{gtp_pkg::STY_AUTO, "0123456789abcdef-FEDCBA9876543210", 1, -1, 8'h00,
        1'b1, 1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210},
      '{gtp_pkg::STY_AUTO, "[01234567-89ab-cdef-0123-456789abcdef)", 1, -1, 8'h00,
        1'b1, 1'b0, 64'h0, 64'h0},
      '{gtp_pkg::STY_AUTO, "{01234567-89ab-cdef-0123-456789abcdef)", 1, -1, 8'h00,
        1'b1, 1'b0, 64'h0, 64'h0},
      '{gtp_pkg::STY_HEX, "ffffffffffffffffFFFFFFFFFFFFFFFF", 1, -1, 8'h00,
        1'b1, 1'b1, 64'hffffffffffffffff, 64'hffffffffffffffff},
      '{gtp_pkg::STY_HEX, "00000000000000000000000000000000", 1, -1, 8'h00,
        1'b1, 1'b1, 64'h0, 64'h0},
      '{gtp_pkg::STY_HEX, "9AaFf09aAfF0123456789ABCDEFabcde", 1, -1, 8'h00,
        1'b0, 1'b0, 64'h0, 64'h0},
      '{gtp_pkg::STY_HEX, "0123456789:bcdef/123456789ABCDEF", 1, -1, 8'h00,
        1'b1, 1'b0, 64'h0, 64'h0},
      '{gtp_pkg::STY_HEX, "0123456789abcdefFEDCBA9876543210", 1, 5, 8'h00,
        1'b1, 1'b0, 64'h0, 64'h0},
      '{gtp_pkg::STY_HEX, "0123456789abcdefFEDCBA9876543210", 1, 31, 8'hff,
        1'b1, 1'b0, 64'h0, 64'h0},
      '{gtp_pkg::STY_HYP, "01234567_89ab-cdef-0123-456789abcdef", 1, -1, 8'h00,
        1'b1, 1'b0, 64'h0, 64'h0},
      '{gtp_pkg::STY_BRC, "(01234567-89ab-cdef-0123-456789abcdef)", 1, -1, 8'h00,
        1'b1, 1'b0, 64'h0, 64'h0},
      '{gtp_pkg::STY_PAR, "(89ABCDEF-0123-4567-89ab-cdef01234567)", 1, -1, 8'h00,
        1'b0, 1'b0, 64'h0, 64'h0},
      '{gtp_pkg::STY_VAL,
        "{0X01234567,0x89ab,0xcdef,{0x01,0x23,0x45,0x67,0x89,0xab,0xcd,0xef}}",
        1, -1, 8'h00, 1'b1, 1'b0, 64'h0, 64'h0},
      '{gtp_pkg::STY_VAL,
        "{0x01234567,0x89ab,0xcdef,{0x01,0x23,0x45,0x67,0x89,0xab,0xcd,0xef}}}",
        1, -1, 8'h00, 1'b1, 1'b0, 64'h0, 64'h0},
      '{gtp_pkg::STY_W64, "0123456789abcdef-0123456789abcdeg", 1, -1, 8'h00,
        1'b1, 1'b0, 64'h0, 64'h0},
      '{gtp_pkg::STY_W64, "89ABCDEF01234567-0123456789ABCDEF", 1, -1, 8'h00,
        1'b0, 1'b0, 64'h0, 64'h0},
      '{gtp_pkg::STY_BAD, "0123456789abcdefFEDCBA9876543210", 1, -1, 8'h00,
        1'b1, 1'b0, 64'h0, 64'h0},
      '{gtp_pkg::STY_AUTO, "A", 1, -1, 8'h00, 1'b1, 1'b0, 64'h0, 64'h0},
      '{gtp_pkg::STY_AUTO, "0123456789", 10, -1, 8'h00, 1'b1, 1'b0, 64'h0, 64'h0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < N_DIR; r++) begin
      if (dir_tab[r].sty != cur_style) set_style(dir_tab[r].sty);
      txt_q.delete();
      repeat (dir_tab[r].rep)
        for (i = 0; i < dir_tab[r].txt.len(); i++) txt_q.push_back(dir_tab[r].txt[i]);
      if (dir_tab[r].pos >= 0) txt_q[dir_tab[r].pos] = dir_tab[r].sub;
      tr.chk = dir_tab[r].chk;
      tr.res.vld = dir_tab[r].vld;
      tr.res.hi = dir_tab[r].hi;
      tr.res.lo = dir_tab[r].lo;
      row_exp_q.push_back(tr);
      send_text();
    end

    for (ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 14 : (ph == 1) ? 46 : 0;
      goal = n_sent + 190;
      n_str = 0;
      next_cfg = $urandom_range(1, 3);
      while (n_sent < goal || n_str < 4) begin
        if (n_str == next_cfg) begin
          if ($urandom_range(0, 9) < 5) set_style(gtp_pkg::STY_AUTO);
          else set_style(gtp_pkg::style_t'($urandom_range(1, 7)));
          next_cfg += $urandom_range(1, 3);
        end
        build_text();
        send_text();
        n_str++;
      end
    end

    in_start <= 1'b0;
    @(posedge clk);
    for (i = 0; i < 1000 && guid_exp_q.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (guid_exp_q.size() != 0) begin
      $error("%0d results never arrived", guid_exp_q.size());
      n_err++;
    end
    if (n_err == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
